>>> rtl/cvf_pkg.sv
package cvf_pkg;

   // Default sizes handed to the top level parameters
   localparam int KEY_BYTES_DEF        = 8;
   localparam int MAX_HEADER_BYTES_DEF = 4096;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int KEY_LEN_W   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 2'd1;

   // Header characters
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VTAB   = 8'h0B;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;

   // Status of one parse step
   typedef struct packed {
      logic emit;      // step produces a result transaction
      logic found;     // key matched
      logic too_long;  // position saturated
   } parse_result_type;

endpackage

>>> rtl/cvf_parser.sv
module cvf_parser
   import cvf_pkg::*;
#(
   parameter int KEY_BYTES        = KEY_BYTES_DEF,
   parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF,
   localparam int OFS_W           = $clog2(MAX_HEADER_BYTES),
   localparam int POS_W           = $clog2(MAX_HEADER_BYTES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic [7:0]             byte_in,
   input  logic                   last_in,
   input  logic [KEY_BYTES*8-1:0] key_bytes,
   input  logic [KEY_LEN_W-1:0]   key_length,
   output parse_result_type       result,
   output logic [OFS_W-1:0]       value_offset,
   output logic [POS_W-1:0]       value_length
);

   localparam logic [1:0] PH_SKIP  = 2'd0;
   localparam logic [1:0] PH_KEY   = 2'd1;
   localparam logic [1:0] PH_VALUE = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   localparam logic [POS_W-1:0]     POS_MAX = POS_W'(MAX_HEADER_BYTES);
   localparam logic [OFS_W-1:0]     OFS_MAX = OFS_W'(MAX_HEADER_BYTES - 1);
   localparam logic [KEY_LEN_W-1:0] KLEN_MAX = KEY_LEN_W'(KEY_BYTES);
   localparam logic [KEY_LEN_W-1:0] KCNT_SAT = '1;

   logic [1:0]           phase_ff, phase_in;
   logic [POS_W-1:0]     position_ff, position_in;
   logic [KEY_LEN_W-1:0] key_count_ff, key_count_in;
   logic                 key_mismatch_ff, key_mismatch_in;
   logic [OFS_W-1:0]     value_start_ff, value_start_in;
   logic [OFS_W-1:0]     segment_start_ff, segment_start_in;
   logic                 saw_equals_ff, saw_equals_in;
   logic                 overflowed_ff, overflowed_in;

   logic [KEY_LEN_W-1:0] klen;
   logic [7:0]           key_byte;
   logic                 at_bound;
   logic [POS_W:0]       idx_next;
   logic [OFS_W-1:0]     off_here;
   logic [OFS_W-1:0]     off_next;
   logic [POS_W-1:0]     end_next;
   logic                 is_ws;
   logic                 is_eq;
   logic                 is_semi;

   assign klen     = (key_length > KLEN_MAX) ? KLEN_MAX : key_length;
   assign at_bound = (position_ff >= POS_MAX);
   assign idx_next = {1'b0, position_ff} + 1'b1;
   assign off_here = at_bound ? OFS_MAX : position_ff[OFS_W-1:0];
   assign off_next = (position_ff >= POS_MAX - 1'b1) ? OFS_MAX : idx_next[OFS_W-1:0];
   assign end_next = at_bound ? POS_MAX : idx_next[POS_W-1:0];
   assign is_ws    = (byte_in == CH_SPACE) || (byte_in == CH_TAB) || (byte_in == CH_VTAB);
   assign is_eq    = (byte_in == CH_EQUALS);
   assign is_semi  = (byte_in == CH_SEMI);

   // Key byte at the current compare position
   always_comb begin
      key_byte = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (key_count_ff[2:0] == 3'(i)) begin
            key_byte = key_bytes[8*i +: 8];
         end
      end
   end

   always_comb begin
      logic             ended;
      logic [POS_W-1:0] endpos;
      logic             match;
      logic [OFS_W-1:0] start;

      phase_in         = phase_ff;
      position_in      = at_bound ? position_ff : idx_next[POS_W-1:0];
      key_count_in     = key_count_ff;
      key_mismatch_in  = key_mismatch_ff;
      value_start_in   = value_start_ff;
      segment_start_in = segment_start_ff;
      saw_equals_in    = saw_equals_ff;
      overflowed_in    = overflowed_ff | at_bound;
      ended            = 1'b0;
      endpos           = position_ff;
      match            = 1'b0;
      start            = '0;
      result           = '0;
      value_offset     = '0;
      value_length     = '0;

      case (phase_ff)
         PH_SKIP: begin
            if (is_ws) begin
               if (last_in) begin
                  segment_start_in = off_next;
                  key_count_in     = '0;
                  key_mismatch_in  = 1'b0;
                  saw_equals_in    = 1'b0;
               end
            end else begin
               segment_start_in = off_here;
               key_count_in     = '0;
               key_mismatch_in  = 1'b0;
               saw_equals_in    = 1'b0;
               phase_in         = PH_KEY;
               if (is_eq) begin
                  saw_equals_in   = 1'b1;
                  key_mismatch_in = (klen != '0);
                  value_start_in  = off_next;
                  phase_in        = PH_VALUE;
               end else if (is_semi) begin
                  ended = 1'b1;
               end else begin
                  key_mismatch_in = (klen == '0) || (byte_in != key_bytes[7:0]);
                  key_count_in    = KEY_LEN_W'(1);
               end
            end
         end
         PH_KEY: begin
            if (is_eq) begin
               saw_equals_in   = 1'b1;
               key_mismatch_in = key_mismatch_ff | (key_count_ff != klen);
               value_start_in  = off_next;
               phase_in        = PH_VALUE;
            end else if (is_semi) begin
               ended = 1'b1;
            end else begin
               key_mismatch_in = key_mismatch_ff | (key_count_ff >= klen)
                                 | (byte_in != key_byte);
               if (key_count_ff != KCNT_SAT) begin
                  key_count_in = key_count_ff + 1'b1;
               end
            end
         end
         PH_VALUE: begin
            if (is_semi) begin
               ended = 1'b1;
            end
         end
         default: begin
            // done: ignore the rest of the header
         end
      endcase

      // Final byte closes an open segment just past the header
      if (!ended && last_in && (phase_ff != PH_DONE)) begin
         ended  = 1'b1;
         endpos = end_next;
      end

      if (ended) begin
         if (saw_equals_in) begin
            match = !key_mismatch_in;
            start = value_start_in;
         end else begin
            match = (klen == '0);
            start = segment_start_in;
         end
         if (match) begin
            result.emit     = 1'b1;
            result.found    = 1'b1;
            result.too_long = overflowed_in;
            value_offset    = start;
            value_length    = endpos - POS_W'(start);
            phase_in        = PH_DONE;
         end else begin
            phase_in = PH_SKIP;
         end
      end

      if (last_in) begin
         if (!result.emit) begin
            result.emit     = (phase_ff != PH_DONE);
            result.too_long = overflowed_in;
         end
         phase_in         = PH_SKIP;
         position_in      = '0;
         key_count_in     = '0;
         key_mismatch_in  = 1'b0;
         value_start_in   = '0;
         segment_start_in = '0;
         saw_equals_in    = 1'b0;
         overflowed_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SKIP;
         position_ff      <= '0;
         key_count_ff     <= '0;
         key_mismatch_ff  <= 1'b0;
         value_start_ff   <= '0;
         segment_start_ff <= '0;
         saw_equals_ff    <= 1'b0;
         overflowed_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         position_ff      <= position_in;
         key_count_ff     <= key_count_in;
         key_mismatch_ff  <= key_mismatch_in;
         value_start_ff   <= value_start_in;
         segment_start_ff <= segment_start_in;
         saw_equals_ff    <= saw_equals_in;
         overflowed_ff    <= overflowed_in;
      end
   end

   // Done needs at least one byte seen in this header
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (position_ff != '0))
      else $error("done phase with zero position");

   // Value phase is only entered through an equals sign
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_VALUE) |-> saw_equals_ff)
      else $error("value phase without equals");

   // Final byte returns the parse state to its start
   assert property (@(posedge clock) disable iff (reset)
      (step_en && last_in) |=> ((position_ff == '0) && (phase_ff == PH_SKIP)
                                && !overflowed_ff))
      else $error("parse state not cleared after final byte");

endmodule

>>> rtl/cookie_value_finder.sv
// Cookie value finder.
// Feed a cookie header on the req_ stream, one byte per transaction, with
// req_tlast on the final byte. Segments split at ';'; leading space, tab
// and vertical tab are skipped and the key runs up to the first '='. Load
// the searched key through the csr_ channel (index 0: key bytes, byte 0
// lowest; index 1: key length) while no header is in flight.
// The rsp_ stream returns at most one transaction per header: found with
// the value offset and length at the end of the first matching segment,
// or not found on the final byte. Bytes after a match are swallowed.
// A byte accepted into the input register steps the parser from there, and
// its result is registered in the output register. Throughput: one byte per
// cycle while no result waits on a stalled output register.
// When rsp_tready is low, the result holds in the output register and the
// input register still drains bytes that make no result; a byte that
// would make a second result waits, and req_tready drops once it does.
// Reset (synchronous, active high) clears the key, the parser and both
// registers. Positions saturate at MAX_HEADER_BYTES and set too_long.
module cookie_value_finder
   import cvf_pkg::*;
#(
   parameter int KEY_BYTES        = KEY_BYTES_DEF,
   parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF,
   localparam int OFS_W           = $clog2(MAX_HEADER_BYTES),
   localparam int LEN_W           = $clog2(MAX_HEADER_BYTES + 1),
   localparam int RSP_DATA_W      = ((OFS_W + LEN_W + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,

   // header byte stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // header_byte
   input  logic                   req_tlast,   // last_byte

   // lookup result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // value_offset, value_length, zero pad
   output logic [1:0]             rsp_tuser,   // found, too_long

   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [KEY_BYTES*8-1:0] key_bytes_ff;
   logic [KEY_LEN_W-1:0]   key_length_ff;

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_found_ff;
   logic                   rsp_too_long_ff;
   logic [OFS_W-1:0]       rsp_offset_ff;
   logic [LEN_W-1:0]       rsp_length_ff;

   parse_result_type       res;
   logic [OFS_W-1:0]       res_offset;
   logic [LEN_W-1:0]       res_length;
   logic                   advance;
   logic                   emit;

   // Registers are always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff  <= '0;
         key_length_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY_BYTES:  key_bytes_ff  <= csr_data[KEY_BYTES*8-1:0];
            CSR_KEY_LENGTH: key_length_ff <= csr_data[KEY_LEN_W-1:0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   cvf_parser #(
      .KEY_BYTES        (KEY_BYTES),
      .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .byte_in      (in_byte_ff),
      .last_in      (in_last_ff),
      .key_bytes    (key_bytes_ff),
      .key_length   (key_length_ff),
      .result       (res),
      .value_offset (res_offset),
      .value_length (res_length)
   );

   // Step the held byte unless its result would overwrite a stalled one
   assign advance    = in_valid_ff && (!res.emit || !rsp_valid_ff || rsp_tready);
   assign emit       = advance && res.emit;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_found_ff    <= res.found;
         rsp_too_long_ff <= res.too_long;
         rsp_offset_ff   <= res_offset;
         rsp_length_ff   <= res_length;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_too_long_ff, rsp_found_ff};

   always_comb begin
      rsp_tdata                = '0;
      rsp_tdata[OFS_W-1:0]     = rsp_offset_ff;
      rsp_tdata[OFS_W +: LEN_W] = rsp_length_ff;
   end

   // Not found carries zero offset and length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> ((rsp_offset_ff == '0) && (rsp_length_ff == '0)))
      else $error("not-found result with nonzero position");

   // A found value ends inside the position bound
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff)
         |-> ((int'(rsp_offset_ff) + int'(rsp_length_ff)) <= MAX_HEADER_BYTES))
      else $error("found value runs past the header bound");

   // An accepted byte always lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted byte lost");

endmodule

>>> test/cookie_lookup_checker.sv
module cookie_lookup_checker
   import cvf_pkg::*;
#(
   parameter int RSP_DATA_W = 32
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,

   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [1:0]             rsp_tuser,

   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,

   output int                     mismatch_count,
   output int                     lookups_pending
);

   localparam int MAX_POS = MAX_HEADER_BYTES_DEF;
   localparam int OFS_W   = $clog2(MAX_POS);
   localparam int LEN_W   = $clog2(MAX_POS + 1);

   typedef enum logic [1:0] {SKIP_WS, IN_KEY, IN_VALUE, SWALLOW} parse_phase_type;

   typedef struct packed {
      logic             found;
      logic [OFS_W-1:0] offset;
      logic [LEN_W-1:0] length;
      logic             too_long;
   } lookup_type;

   logic [CSR_DATA_W-1:0] key_bytes;
   logic [KEY_LEN_W-1:0]  key_length;

   parse_phase_type       phase;
   logic [LEN_W-1:0]      position;
   logic [3:0]            key_count;
   logic                  key_mismatch;
   logic [OFS_W-1:0]      value_start;
   logic [OFS_W-1:0]      segment_start;
   logic                  saw_equals;
   logic                  overflowed;

   lookup_type            expected_lookups[$];
   int                    failures;

   function automatic logic [OFS_W-1:0] clamp_offset(input logic [LEN_W:0] p);
      return (p > MAX_POS - 1) ? OFS_W'(MAX_POS - 1) : p[OFS_W-1:0];
   endfunction

   function automatic logic [LEN_W:0] clamp_end(input logic [LEN_W:0] p);
      return (p > MAX_POS) ? (LEN_W + 1)'(MAX_POS) : p;
   endfunction

   task automatic open_segment(input logic [OFS_W-1:0] start);
      segment_start = start;
      key_count     = '0;
      key_mismatch  = 1'b0;
      saw_equals    = 1'b0;
   endtask

   task automatic clear_parse();
      phase         = SKIP_WS;
      position      = '0;
      key_count     = '0;
      key_mismatch  = 1'b0;
      value_start   = '0;
      segment_start = '0;
      saw_equals    = 1'b0;
      overflowed    = 1'b0;
   endtask

   // Advance the parser by one header byte; queue the lookup result it causes.
   task automatic parse_header_byte(input logic [7:0] b, input logic last);
      logic [3:0]       klen;
      logic [LEN_W:0]   idx;
      logic [LEN_W:0]   end_pos;
      logic [OFS_W-1:0] start;
      logic             blank;
      logic             ended;
      logic             emitted;
      logic             match;
      lookup_type       res;
      klen    = (key_length > KEY_BYTES_DEF) ? 4'(KEY_BYTES_DEF) : key_length;
      idx     = {1'b0, position};
      blank   = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VTAB);
      ended   = 1'b0;
      emitted = 1'b0;
      match   = 1'b0;
      end_pos = '0;
      start   = '0;

      if (idx >= MAX_POS) begin
         overflowed = 1'b1;
         idx        = (LEN_W + 1)'(MAX_POS);
      end else begin
         position = idx[LEN_W-1:0] + 1'b1;
      end

      case (phase)
         SKIP_WS: begin
            if (blank) begin
               if (last) open_segment(clamp_offset(idx + 1'b1));
            end else begin
               open_segment(clamp_offset(idx));
               phase = IN_KEY;
               if (b == CH_EQUALS) begin
                  saw_equals = 1'b1;
                  if (klen != 0) key_mismatch = 1'b1;
                  value_start = clamp_offset(idx + 1'b1);
                  phase       = IN_VALUE;
               end else if (b == CH_SEMI) begin
                  ended   = 1'b1;
                  end_pos = idx;
               end else begin
                  if (klen == 0 || b != key_bytes[7:0]) key_mismatch = 1'b1;
                  key_count = 4'd1;
               end
            end
         end
         IN_KEY: begin
            if (b == CH_EQUALS) begin
               saw_equals = 1'b1;
               if (key_count != klen) key_mismatch = 1'b1;
               value_start = clamp_offset(idx + 1'b1);
               phase       = IN_VALUE;
            end else if (b == CH_SEMI) begin
               ended   = 1'b1;
               end_pos = idx;
            end else begin
               if (key_count >= klen || b != key_bytes[8*key_count[2:0] +: 8])
                  key_mismatch = 1'b1;
               if (key_count < 4'd15) key_count = key_count + 1'b1;
            end
         end
         IN_VALUE: begin
            if (b == CH_SEMI) begin
               ended   = 1'b1;
               end_pos = idx;
            end
         end
         default: ;
      endcase

      if (!ended && last && phase != SWALLOW) begin
         ended   = 1'b1;
         end_pos = clamp_end(idx + 1'b1);
      end

      if (ended) begin
         if (saw_equals) begin
            match = !key_mismatch;
            start = value_start;
         end else begin
            match = (klen == 0);
            start = segment_start;
         end
         if (match) begin
            res.found    = 1'b1;
            res.offset   = start;
            res.length   = LEN_W'(end_pos - start);
            res.too_long = overflowed;
            expected_lookups.push_back(res);
            emitted = 1'b1;
            phase   = SWALLOW;
         end else begin
            phase = SKIP_WS;
         end
      end

      if (last) begin
         // not found, unless an earlier segment already reported
         if (!emitted && !(phase == SWALLOW && !ended)) begin
            res.found    = 1'b0;
            res.offset   = '0;
            res.length   = '0;
            res.too_long = overflowed;
            expected_lookups.push_back(res);
         end
         clear_parse();
      end
   endtask

   task automatic report_mismatch(input string what, input lookup_type want,
                                  input lookup_type seen,
                                  input logic [RSP_DATA_W-1:0] data);
      failures++;
      if (failures <= 10)
         $display("%0t: %s: expected found=%0d offset=%0d length=%0d too_long=%0d pad=0,",
                  $time, what, want.found, want.offset, want.length, want.too_long,
                  " got found=%0d offset=%0d length=%0d too_long=%0d pad=%0h",
                  seen.found, seen.offset, seen.length, seen.too_long,
                  data[RSP_DATA_W-1:OFS_W+LEN_W]);
   endtask

   always @(posedge clock) begin : monitor
      lookup_type seen;
      lookup_type want;
      if (reset) begin
         key_bytes  = '0;
         key_length = '0;
         clear_parse();
         expected_lookups.delete();
         failures   = 0;
      end else begin
         // compare first: a result never stems from a byte taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            seen.found    = rsp_tuser[0];
            seen.too_long = rsp_tuser[1];
            seen.offset   = rsp_tdata[OFS_W-1:0];
            seen.length   = rsp_tdata[OFS_W+LEN_W-1:OFS_W];
            if (expected_lookups.size() == 0) begin
               want = '0;
               report_mismatch("result with no lookup outstanding", want, seen, rsp_tdata);
            end else begin
               want = expected_lookups.pop_front();
               if (seen.found !== want.found || seen.offset !== want.offset ||
                   seen.length !== want.length || seen.too_long !== want.too_long ||
                   rsp_tdata[RSP_DATA_W-1:OFS_W+LEN_W] !== '0)
                  report_mismatch("lookup mismatch", want, seen, rsp_tdata);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_BYTES:  key_bytes  = csr_data;
               CSR_KEY_LENGTH: key_length = csr_data[KEY_LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) parse_header_byte(req_tdata, req_tlast);
      end
      mismatch_count  <= failures;
      lookups_pending <= expected_lookups.size();
   end

endmodule

>>> test/testbench.sv
module testbench;
   import cvf_pkg::*;

   localparam int OFS_W      = $clog2(MAX_HEADER_BYTES_DEF);
   localparam int LEN_W      = $clog2(MAX_HEADER_BYTES_DEF + 1);
   localparam int RSP_DATA_W = ((OFS_W + LEN_W + 7) / 8) * 8;

   // An index that maps to no register; writes to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   // Random header bytes per register setting, long headers not counted.
   localparam int BYTES_PER_PHASE = 110;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tlast  = 1'b0;

   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [1:0]             rsp_tuser;

   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int                     mismatch_count;
   int                     lookups_pending;

   // Idle odds in percent for the byte sender and the result receiver.
   int                     req_idle_pct = 0;
   int                     rsp_idle_pct = 0;

   // Key currently loaded, and its length as the block uses it (0..8).
   logic [CSR_DATA_W-1:0]  search_key;
   int                     search_len;

   // Header being built for the next send.
   logic [7:0]             header_text[$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cookie_value_finder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cookie_lookup_checker #(
      .RSP_DATA_W (RSP_DATA_W)
   ) lookup_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .lookups_pending (lookups_pending)
   );

   // Stall the result channel at random, one decision per cycle.
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);

   // Hard stop: far above the slowest legal run, even with every stall at its worst.
   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 2))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         default: return CH_VTAB;
      endcase
   endfunction

   // Random byte that never closes a segment; optionally never an '=' either.
   function automatic logic [7:0] pick_text(input bit allow_equals);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CH_SEMI || (!allow_equals && c == CH_EQUALS));
      return c;
   endfunction

   // Drive one header byte at the falling edge, idling first at random,
   // and hold it until the transaction completes.
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_header();
      for (int i = 0; i < header_text.size(); i++)
         send_byte(header_text[i], i == header_text.size() - 1);
   endtask

   task automatic send_text(input string s);
      header_text.delete();
      for (int i = 0; i < s.len(); i++) header_text.push_back(s[i]);
      send_header();
   endtask

   // Drop valid, wait for every outstanding lookup, then let the pipeline
   // settle so that swallowed bytes are out of the block before any write.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (lookups_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Build a header of 1..4 segments, mostly well formed around the loaded key.
   // A nonzero filler_len, if the first segment gets an '=', gives its value that many bytes, near or past the bound.
   task automatic build_header(input int filler_len);
      int segments;
      int kind;
      int n;
      int keep;
      int flip;
      header_text.delete();
      segments = $urandom_range(1, 4);
      for (int s = 0; s < segments; s++) begin
         repeat ($urandom_range(0, 2)) header_text.push_back(pick_blank());
         kind = $urandom_range(0, 9);
         case (kind)
            7: begin
               // no '=': the whole segment is a value with an empty key
               repeat ($urandom_range(0, 5)) header_text.push_back(pick_text(1'b0));
            end
            9: begin
               // raw noise, separators included
               repeat ($urandom_range(0, 6)) header_text.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
               if (kind == 8) begin
                  // empty key
               end else if (kind == 5) begin
                  // one key byte replaced
                  flip = (search_len == 0) ? 0 : $urandom_range(0, search_len - 1);
                  for (int i = 0; i < search_len; i++)
                     header_text.push_back(i == flip ? pick_text(1'b0) : search_key[8*i +: 8]);
                  if (search_len == 0) header_text.push_back(pick_text(1'b0));
               end else if (kind == 6) begin
                  // key one byte too long or too short
                  n = $urandom_range(0, 1) ? search_len + 1 : search_len - 1;
                  for (int i = 0; i < n; i++)
                     header_text.push_back(i < search_len ? search_key[8*i +: 8]
                                                          : pick_text(1'b0));
               end else begin
                  for (int i = 0; i < search_len; i++)
                     header_text.push_back(search_key[8*i +: 8]);
               end
               header_text.push_back(CH_EQUALS);
               n = (s == 0 && filler_len > 0) ? filler_len : $urandom_range(0, 4);
               repeat (n) header_text.push_back(pick_text(1'b1));
            end
         endcase
         if (s < segments - 1) header_text.push_back(CH_SEMI);
      end
      if ($urandom_range(0, 9) == 0) header_text.push_back(CH_SEMI);
      // cut some headers short, in the middle of whatever is open
      if (filler_len == 0 && $urandom_range(0, 9) == 0 && header_text.size() > 1) begin
         keep = $urandom_range(1, header_text.size() - 1);
         while (header_text.size() > keep) void'(header_text.pop_back());
      end
      if (header_text.size() == 0) header_text.push_back(pick_text(1'b1));
   endtask

   initial begin : stimulus
      int sent;
      int raw_len;
      bit long_done;
      logic [CSR_DATA_W-1:0] len_word;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 35;
      rsp_idle_pct = 58;

      // Reset key is empty: a blank-only header and a leading '=' both match.
      header_text = '{CH_SPACE, CH_TAB, CH_VTAB};
      send_header();
      send_text("=v");
      drain();

      // Writes to an unmapped index must leave the key alone.
      write_reg(CSR_UNMAPPED, {$urandom, $urandom});
      search_key = 64'h0000_0000_0000_6261;
      search_len = 2;
      write_reg(CSR_KEY_BYTES, search_key);
      write_reg(CSR_KEY_LENGTH, 64'd2);

      // Mismatching bare segment, blank before the key, trailing ';' on the last byte.
      send_text("q;\tab=xy;");
      // Key with no '=', ending on a byte with the high bit set.
      header_text = '{8'h61, 8'h62, 8'hFF};
      send_header();
      // Key longer than the searched one.
      send_text("abc=1");
      drain();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               req_idle_pct = 35;
               rsp_idle_pct = 58;
               raw_len      = $urandom_range(1, 7);
            end
            1: begin
               req_idle_pct = 58;
               rsp_idle_pct = 35;
               raw_len      = KEY_BYTES_DEF;
            end
            2: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
               raw_len      = $urandom_range(KEY_BYTES_DEF + 1, 15);
            end
            default: raw_len = 0;
         endcase
         search_len = (raw_len > KEY_BYTES_DEF) ? KEY_BYTES_DEF : raw_len;

         // Fill all eight key bytes; the first never a blank so the key can match.
         search_key = '0;
         do search_key[7:0] = pick_text(1'b0);
         while (search_key[7:0] == CH_SPACE || search_key[7:0] == CH_TAB ||
                search_key[7:0] == CH_VTAB);
         for (int i = 1; i < 8; i++) search_key[8*i +: 8] = pick_text(1'b0);

         // Junk above the length field on one setting; the block keeps only the low bits.
         len_word = (p == 2) ? {$urandom, $urandom} : '0;
         len_word[KEY_LEN_W-1:0] = KEY_LEN_W'(raw_len);
         write_reg(CSR_KEY_BYTES, search_key);
         write_reg(CSR_KEY_LENGTH, len_word);

         sent      = 0;
         long_done = (p % 2 != 0);
         while (sent < BYTES_PER_PHASE) begin
            build_header(0);
            sent += header_text.size();
            send_header();
            // On even settings, one header near or past the position bound, midway through the phase.
            if (!long_done && sent >= BYTES_PER_PHASE / 2) begin
               build_header($urandom_range(MAX_HEADER_BYTES_DEF - 8, MAX_HEADER_BYTES_DEF + 4));
               send_header();
               long_done = 1'b1;
            end
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
